FILE: rtl/pidc_pkg.sv
`timescale 1ns / 1ps
package pidc_pkg;

  // Fraction bits of the Q-format gains.
  localparam int GAIN_FRAC_BITS = 8;

  localparam int MEAS_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 16;
  localparam int ERR_W     = MEAS_W + 1;
  localparam int SUM_W     = 32;
  localparam int OPP_W     = ERR_W + 1;
  localparam int OPD_W     = ERR_W + 2;
  localparam int PRODP_W   = GAIN_W + OPP_W;
  localparam int PRODI_W   = GAIN_W + SUM_W;
  localparam int PRODD_W   = GAIN_W + OPD_W;
  localparam int ACC_W     = PRODI_W + 2;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CTRL_W    = 3;

  // Bit positions in the control register.
  localparam int CTRL_OUT_CLAMP = 0;
  localparam int CTRL_INT_CLAMP = 1;
  localparam int CTRL_INCR      = 2;

  localparam logic [CFG_W-1:0] OUT_BOUNDS_RST = 32'h7FFF_8000;
  localparam logic [SUM_W-1:0] INT_UPPER_RST  = 32'h7FFF_FFFF;
  localparam logic [SUM_W-1:0] INT_FLOOR_RST  = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL    = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_SETPOINT   = 3'd4,
    REG_OUT_BOUNDS = 3'd5,
    REG_INT_UPPER  = 3'd6,
    REG_INT_FLOOR  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                incr_mode;
    logic                int_clamp_en;
    logic                out_clamp_en;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [MEAS_W-1:0]   setpoint;
    logic [DRIVE_W-1:0]  out_upper;
    logic [DRIVE_W-1:0]  out_floor;
    logic [SUM_W-1:0]    int_upper;
    logic [SUM_W-1:0]    int_floor;
  } cfg_t;

endpackage

FILE: rtl/pid_controller_dual_mode_core.sv
`timescale 1ns / 1ps
// PID controller with positional and incremental modes.
//
// Input stream (s_t*): one signed 16-bit measurement per item in s_tdata_i.
// Output stream (m_t*): one result per item; m_tdata_o carries the signed
// drive value (or the increment in incremental mode), m_tuser_o is set when
// saturation or the output limits changed that value.
// Configuration: a write with cfg_we_i high stores cfg_data_i into register
// cfg_idx_i and clears the error history and the integral. Write only while
// no item is in flight.
//
// Throughput is one item per clock while the receiver does not stall. The path is
// four register stages: input, error/operand, product and output. An accepted item
// passes through these registers in that order before it appears on m_tvalid_o.
// Reset loads the register defaults, clears the history and empties the
// pipeline. When the receiver stalls, each stage holds its item and bubbles
// are squeezed out; s_tready_o falls only once all four stages are full.
module pid_controller_dual_mode_core
  import pidc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [MEAS_W-1:0]    s_tdata_i,   // [15:0] measurement
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [DRIVE_W-1:0]   m_tdata_o,   // [15:0] drive
  output logic                 m_tuser_o,   // [0] clamped
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t               cfg;
  logic               clear;
  logic               op_valid;
  logic               op_ready;
  logic [OPP_W-1:0]   op_p;
  logic [SUM_W-1:0]   op_i;
  logic [OPD_W-1:0]   op_d;
  logic               prod_valid;
  logic               prod_ready;
  logic [PRODP_W-1:0] prod_p;
  logic [PRODI_W-1:0] prod_i;
  logic [PRODD_W-1:0] prod_d;

  pidc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .clear_o    (clear)
  );

  pidc_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .clear_i    (clear),
    .in_valid_i (s_tvalid_i),
    .in_data_i  (s_tdata_i),
    .in_ready_o (s_tready_o),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_p_o     (op_p),
    .op_i_o     (op_i),
    .op_d_o     (op_d)
  );

  pidc_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .op_p_i       (op_p),
    .op_i_i       (op_i),
    .op_d_i       (op_d),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_p_o     (prod_p),
    .prod_i_o     (prod_i),
    .prod_d_o     (prod_d)
  );

  pidc_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_p_i     (prod_p),
    .prod_i_i     (prod_i),
    .prod_d_i     (prod_d),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .drive_o      (m_tdata_o),
    .clamped_o    (m_tuser_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (m_tvalid_o && !m_tready_i && prod_valid && op_valid))
    else $error("input stalled while the pipeline has room");

endmodule

FILE: rtl/pidc_cfg.sv
`timescale 1ns / 1ps
module pidc_cfg
  import pidc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o,
  output logic                 clear_o
);

  logic [CTRL_W-1:0]  ctrl_q;
  logic [GAIN_W-1:0]  gain_p_q;
  logic [GAIN_W-1:0]  gain_i_q;
  logic [GAIN_W-1:0]  gain_d_q;
  logic [MEAS_W-1:0]  setpoint_q;
  logic [CFG_W-1:0]   out_bounds_q;
  logic [SUM_W-1:0]   int_upper_q;
  logic [SUM_W-1:0]   int_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= '0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      setpoint_q   <= '0;
      out_bounds_q <= OUT_BOUNDS_RST;
      int_upper_q  <= INT_UPPER_RST;
      int_floor_q  <= INT_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CONTROL:    ctrl_q       <= cfg_data_i[CTRL_W-1:0];
        REG_GAIN_P:     gain_p_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_q     <= cfg_data_i[GAIN_W-1:0];
        REG_SETPOINT:   setpoint_q   <= cfg_data_i[MEAS_W-1:0];
        REG_OUT_BOUNDS: out_bounds_q <= cfg_data_i;
        REG_INT_UPPER:  int_upper_q  <= cfg_data_i[SUM_W-1:0];
        REG_INT_FLOOR:  int_floor_q  <= cfg_data_i[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Every register index is defined, so any write restarts the history.
  assign clear_o = cfg_we_i;

  always_comb begin
    cfg_o.incr_mode    = ctrl_q[CTRL_INCR];
    cfg_o.int_clamp_en = ctrl_q[CTRL_INT_CLAMP];
    cfg_o.out_clamp_en = ctrl_q[CTRL_OUT_CLAMP];
    cfg_o.gain_p       = gain_p_q;
    cfg_o.gain_i       = gain_i_q;
    cfg_o.gain_d       = gain_d_q;
    cfg_o.setpoint     = setpoint_q;
    cfg_o.out_upper    = out_bounds_q[CFG_W-1:CFG_W-DRIVE_W];
    cfg_o.out_floor    = out_bounds_q[DRIVE_W-1:0];
    cfg_o.int_upper    = int_upper_q;
    cfg_o.int_floor    = int_floor_q;
  end

endmodule

FILE: rtl/pidc_err.sv
`timescale 1ns / 1ps
module pidc_err
  import pidc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              clear_i,
  input  logic              in_valid_i,
  input  logic [MEAS_W-1:0] in_data_i,
  output logic              in_ready_o,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output logic [OPP_W-1:0]  op_p_o,
  output logic [SUM_W-1:0]  op_i_o,
  output logic [OPD_W-1:0]  op_d_o
);

  localparam int SUMX_W = SUM_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic              in_v_q;
  logic [MEAS_W-1:0] meas_q;
  logic              op_v_q;
  logic [OPP_W-1:0]  op_p_q;
  logic [SUM_W-1:0]  op_i_q;
  logic [OPD_W-1:0]  op_d_q;

  // The oldest error is consumed in the same step that would shift it out,
  // so only the two newest errors are kept.
  logic signed [ERR_W-1:0] err_now_q;
  logic signed [ERR_W-1:0] err_prev_q;
  logic signed [SUM_W-1:0] err_sum_q;

  logic                     op_load;
  logic                     step;
  logic signed [MEAS_W-1:0] sp;
  logic signed [MEAS_W-1:0] meas;
  logic signed [ERR_W-1:0]  err;
  logic signed [OPP_W-1:0]  diff1;
  logic signed [OPD_W-1:0]  diff2;
  logic signed [SUMX_W-1:0] sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  int_hi;
  logic signed [SUM_W-1:0]  int_lo;
  logic [OPP_W-1:0]         op_p_d;
  logic [SUM_W-1:0]         op_i_d;
  logic [OPD_W-1:0]         op_d_d;

  assign op_load    = !op_v_q || op_ready_i;
  assign in_ready_o = !in_v_q || op_load;
  assign step       = in_v_q && op_load;

  assign sp     = cfg_i.setpoint;
  assign meas   = meas_q;
  assign int_hi = cfg_i.int_upper;
  assign int_lo = cfg_i.int_floor;

  always_comb begin
    err      = ERR_W'(sp) - ERR_W'(meas);
    diff1    = OPP_W'(err) - OPP_W'(err_now_q);
    diff2    = OPD_W'(err) - (OPD_W'(err_now_q) <<< 1) + OPD_W'(err_prev_q);
    sum_wide = SUMX_W'(err_sum_q) + SUMX_W'(err);
    // Saturate the running sum to 32 bits before the optional bounds.
    if (sum_wide[SUMX_W-1] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUMX_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    sum_d = sum_sat;
    if (cfg_i.int_clamp_en) begin
      if (sum_sat > int_hi) begin
        sum_d = int_hi;
      end
      if (sum_d < int_lo) begin
        sum_d = int_lo;
      end
    end
    if (cfg_i.incr_mode) begin
      op_p_d = diff1;
      op_i_d = SUM_W'(err);
      op_d_d = diff2;
    end else begin
      op_p_d = OPP_W'(err);
      op_i_d = sum_d;
      op_d_d = OPD_W'(diff1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      op_v_q     <= 1'b0;
      err_now_q  <= '0;
      err_prev_q <= '0;
      err_sum_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (op_load) begin
        op_v_q <= in_v_q;
      end
      if (clear_i) begin
        err_now_q  <= '0;
        err_prev_q <= '0;
        err_sum_q  <= '0;
      end else if (step) begin
        err_now_q  <= err;
        err_prev_q <= err_now_q;
        if (!cfg_i.incr_mode) begin
          err_sum_q <= sum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      meas_q <= in_data_i;
    end
    if (step) begin
      op_p_q <= op_p_d;
      op_i_q <= op_i_d;
      op_d_q <= op_d_d;
    end
  end

  assign op_valid_o = op_v_q;
  assign op_p_o     = op_p_q;
  assign op_i_o     = op_i_q;
  assign op_d_o     = op_d_q;

  a_incr_keeps_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cfg_i.incr_mode && !clear_i) |=> $stable(err_sum_q))
    else $error("integral changed in incremental mode");

  a_sum_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !cfg_i.incr_mode && cfg_i.int_clamp_en && !clear_i && int_lo <= int_hi)
    |=> (err_sum_q <= int_hi && err_sum_q >= int_lo))
    else $error("integral outside its configured bounds");

endmodule

FILE: rtl/pidc_mul.sv
`timescale 1ns / 1ps
module pidc_mul
  import pidc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  input  logic [OPP_W-1:0]   op_p_i,
  input  logic [SUM_W-1:0]   op_i_i,
  input  logic [OPD_W-1:0]   op_d_i,
  output logic               prod_valid_o,
  input  logic               prod_ready_i,
  output logic [PRODP_W-1:0] prod_p_o,
  output logic [PRODI_W-1:0] prod_i_o,
  output logic [PRODD_W-1:0] prod_d_o
);

  logic                      v_q;
  logic signed [PRODP_W-1:0] prod_p_q;
  logic signed [PRODI_W-1:0] prod_i_q;
  logic signed [PRODD_W-1:0] prod_d_q;

  logic                      load;
  logic signed [GAIN_W-1:0]  kp;
  logic signed [GAIN_W-1:0]  ki;
  logic signed [GAIN_W-1:0]  kd;
  logic signed [OPP_W-1:0]   opp;
  logic signed [SUM_W-1:0]   opi;
  logic signed [OPD_W-1:0]   opd;
  logic signed [PRODP_W-1:0] prod_p_d;
  logic signed [PRODI_W-1:0] prod_i_d;
  logic signed [PRODD_W-1:0] prod_d_d;

  assign load       = !v_q || prod_ready_i;
  assign op_ready_o = load;

  assign kp  = cfg_i.gain_p;
  assign ki  = cfg_i.gain_i;
  assign kd  = cfg_i.gain_d;
  assign opp = op_p_i;
  assign opi = op_i_i;
  assign opd = op_d_i;

  assign prod_p_d = PRODP_W'(kp) * PRODP_W'(opp);
  assign prod_i_d = PRODI_W'(ki) * PRODI_W'(opi);
  assign prod_d_d = PRODD_W'(kd) * PRODD_W'(opd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && op_valid_i) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  assign prod_valid_o = v_q;
  assign prod_p_o     = prod_p_q;
  assign prod_i_o     = prod_i_q;
  assign prod_d_o     = prod_d_q;

endmodule

FILE: rtl/pidc_out.sv
`timescale 1ns / 1ps
module pidc_out
  import pidc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               prod_valid_i,
  output logic               prod_ready_o,
  input  logic [PRODP_W-1:0] prod_p_i,
  input  logic [PRODI_W-1:0] prod_i_i,
  input  logic [PRODD_W-1:0] prod_d_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DRIVE_W-1:0] drive_o,
  output logic               clamped_o
);

  localparam int Y_W = ACC_W - GAIN_FRAC_BITS;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  logic               v_q;
  logic [DRIVE_W-1:0] drive_q;
  logic               clamped_q;

  logic                      load;
  logic signed [PRODP_W-1:0] pp;
  logic signed [PRODI_W-1:0] pi;
  logic signed [PRODD_W-1:0] pd;
  logic signed [ACC_W-1:0]   acc;
  logic signed [Y_W-1:0]     y;
  logic signed [DRIVE_W-1:0] y_sat;
  logic signed [DRIVE_W-1:0] drive_d;
  logic signed [DRIVE_W-1:0] out_hi;
  logic signed [DRIVE_W-1:0] out_lo;
  logic                      clamped_d;

  assign load         = !v_q || out_ready_i;
  assign prod_ready_o = load;

  assign pp     = prod_p_i;
  assign pi     = prod_i_i;
  assign pd     = prod_d_i;
  assign out_hi = cfg_i.out_upper;
  assign out_lo = cfg_i.out_floor;

  always_comb begin
    acc = ACC_W'(pp) + ACC_W'(pi) + ACC_W'(pd);
    // Dropping the fraction bits of a two's complement value floors it.
    y         = acc[ACC_W-1:GAIN_FRAC_BITS];
    clamped_d = 1'b0;
    if (y > Y_W'(DRIVE_MAX)) begin
      y_sat     = DRIVE_MAX;
      clamped_d = 1'b1;
    end else if (y < Y_W'(DRIVE_MIN)) begin
      y_sat     = DRIVE_MIN;
      clamped_d = 1'b1;
    end else begin
      y_sat = y[DRIVE_W-1:0];
    end
    drive_d = y_sat;
    if (cfg_i.out_clamp_en) begin
      // The floor is applied last, so it wins over a crossed upper limit.
      if (y_sat > out_hi) begin
        drive_d = out_hi;
      end
      if (drive_d < out_lo) begin
        drive_d = out_lo;
      end
      if (drive_d != y_sat) begin
        clamped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && prod_valid_i) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o = v_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

  a_floor_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && prod_valid_i && cfg_i.out_clamp_en)
    |=> ($signed(drive_q) >= $signed($past(cfg_i.out_floor))))
    else $error("drive below the configured output floor");

  a_unclamped_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && prod_valid_i && !clamped_d) |-> (drive_d == y_sat))
    else $error("drive changed without the clamped flag");

endmodule

FILE: bench/pid_controller_dual_mode_core_tb.sv
`timescale 1ns / 1ps
module pid_controller_dual_mode_core_tb;
  import pidc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic               clamped;
  } drive_item_t;

  class pid_scoreboard;
    logic [CTRL_W-1:0]         ctrl;
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic signed [MEAS_W-1:0]  target;
    logic [CFG_W-1:0]          out_bounds;
    logic signed [SUM_W-1:0]   int_hi, int_lo;
    logic signed [ERR_W-1:0]   e0, e1, e2;
    logic signed [SUM_W-1:0]   err_integral;
    drive_item_t               drive_q[$];
    int                        mismatches;

    function new();
      ctrl       = '0;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      target     = '0;
      out_bounds = OUT_BOUNDS_RST;
      int_hi     = INT_UPPER_RST;
      int_lo     = INT_FLOOR_RST;
      mismatches = 0;
      clear_history();
    endfunction

    function void clear_history();
      e0 = '0;
      e1 = '0;
      e2 = '0;
      err_integral = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CONTROL:    ctrl = val[CTRL_W-1:0];
        REG_GAIN_P:     kp = val[GAIN_W-1:0];
        REG_GAIN_I:     ki = val[GAIN_W-1:0];
        REG_GAIN_D:     kd = val[GAIN_W-1:0];
        REG_SETPOINT:   target = val[MEAS_W-1:0];
        REG_OUT_BOUNDS: out_bounds = val;
        REG_INT_UPPER:  int_hi = val;
        REG_INT_FLOOR:  int_lo = val;
        default: ;
      endcase
      clear_history();
    endfunction

    function void note_input(logic [MEAS_W-1:0] meas);
      longint e, ep, c0, c1, c2, s, acc, y, y_pre, hi, lo, lkp, lki, lkd;
      bit clip;
      lkp = kp;
      lki = ki;
      lkd = kd;
      e = longint'(target) - longint'($signed(meas));
      if (ctrl[CTRL_INCR]) begin
        e2 = e1;
        e1 = e0;
        e0 = e[ERR_W-1:0];
        c0 = e0;
        c1 = e1;
        c2 = e2;
        acc = lkp * (c0 - c1) + lki * c0 + lkd * (c0 - 2 * c1 + c2);
      end else begin
        ep = e0;
        e1 = e0;
        e0 = e[ERR_W-1:0];
        s = longint'(err_integral) + e;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        // The floor is checked last, so it wins when the bounds cross.
        if (ctrl[CTRL_INT_CLAMP]) begin
          if (s > longint'(int_hi)) s = int_hi;
          if (s < longint'(int_lo)) s = int_lo;
        end
        err_integral = s[SUM_W-1:0];
        acc = lkp * e + lki * s + lkd * (e - ep);
      end
      y = acc >>> GAIN_FRAC_BITS;
      clip = 1'b0;
      if (y > 32767) begin
        y = 32767;
        clip = 1'b1;
      end
      if (y < -32768) begin
        y = -32768;
        clip = 1'b1;
      end
      if (ctrl[CTRL_OUT_CLAMP]) begin
        hi = $signed(out_bounds[31:16]);
        lo = $signed(out_bounds[15:0]);
        // Crossed limits can bring the value back to where it started,
        // which does not count as clamping.
        y_pre = y;
        if (y > hi) y = hi;
        if (y < lo) y = lo;
        if (y != y_pre) clip = 1'b1;
      end
      drive_q.push_back('{y[DRIVE_W-1:0], clip});
    endfunction

    function void check_result(logic [DRIVE_W-1:0] drive, logic clamped);
      drive_item_t want;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result drive=%h clamped=%b with no item waiting",
                   $realtime, drive, clamped);
        return;
      end
      want = drive_q.pop_front();
      if (drive !== want.drive || clamped !== want.clamped) begin
        mismatches++;
        if (mismatches <= 10) begin
          if (drive !== want.drive)
            $display("%0t: drive expected %h, got %h", $realtime, want.drive, drive);
          if (clamped !== want.clamped)
            $display("%0t: clamped expected %b, got %b", $realtime, want.clamped, clamped);
        end
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [MEAS_W-1:0]    s_tdata = '0;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tready_o;
  logic                 m_tvalid_o;
  logic [DRIVE_W-1:0]   m_tdata_o;
  logic                 m_tuser_o;

  pid_scoreboard sb = new();
  int  cycles = 0;
  int  idle_pct = 0;
  bit  hold_req = 1'b0;

  pid_controller_dual_mode_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Handshakes are sampled with the values that were stable before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready) sb.check_result(m_tdata_o, m_tuser_o);
      if (s_tvalid && s_tready_o) sb.note_input(s_tdata);
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_sample(input logic [MEAS_W-1:0] meas);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= meas;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_word16();
    int r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return r[15:0];
    endcase
  endfunction

  // Upper bits of narrow registers carry junk that the block must drop.
  function automatic logic [31:0] pad_junk(input logic [15:0] low);
    logic [31:0] w;
    w = $urandom;
    w[15:0] = low;
    return w;
  endfunction

  function automatic logic [31:0] pick_int_bound(input bit upper);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return upper ? INT_UPPER_RST : INT_FLOOR_RST;
      1: return w;
      default: return upper ? 32'($urandom_range(0, 200000))
                            : -32'($urandom_range(0, 200000));
    endcase
  endfunction

  function automatic logic [31:0] pick_out_bounds();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return OUT_BOUNDS_RST;
      1: return w;
      default: return {16'($urandom_range(0, 3000)), -16'($urandom_range(0, 3000))};
    endcase
  endfunction

  initial begin
    logic [31:0] w;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: zero gains give a zero drive.
    offer_sample(16'h0000);
    offer_sample(16'h7FFF);
    offer_sample(16'h8000);
    wait_idle();

    // Proportional only, with the error at both ends of its range.
    write_reg(REG_CONTROL, 32'h0);
    write_reg(REG_GAIN_P, 32'h0100);
    write_reg(REG_GAIN_I, 32'h0);
    write_reg(REG_GAIN_D, 32'h0);
    write_reg(REG_SETPOINT, 32'h8000);
    offer_sample(16'h7FFF);
    offer_sample(16'h8000);
    wait_idle();
    write_reg(REG_SETPOINT, 32'h7FFF);
    offer_sample(16'h8000);
    offer_sample(16'h7FFF);
    offer_sample(16'h0000);
    wait_idle();

    // Integral clamp, then with the floor above the upper bound.
    write_reg(REG_CONTROL, 32'h2);
    write_reg(REG_GAIN_P, 32'h7FFF);
    write_reg(REG_GAIN_I, 32'h8000);
    write_reg(REG_GAIN_D, 32'h0080);
    write_reg(REG_SETPOINT, 32'h0);
    write_reg(REG_INT_UPPER, 32'd1000);
    write_reg(REG_INT_FLOOR, -32'd1000);
    offer_sample(16'h8000);
    offer_sample(16'h7FFF);
    offer_sample(16'h0005);
    wait_idle();
    write_reg(REG_INT_UPPER, -32'd5);
    write_reg(REG_INT_FLOOR, 32'd5);
    offer_sample(16'h0100);
    offer_sample(16'hFF00);
    wait_idle();

    // Output clamp, then with crossed output bounds.
    write_reg(REG_CONTROL, 32'h1);
    write_reg(REG_GAIN_P, 32'h0100);
    write_reg(REG_GAIN_I, 32'h0);
    write_reg(REG_GAIN_D, 32'h0);
    write_reg(REG_OUT_BOUNDS, {16'd100, -16'd100});
    offer_sample(-16'd50);
    offer_sample(-16'd500);
    offer_sample(16'd500);
    wait_idle();
    write_reg(REG_OUT_BOUNDS, {-16'd50, 16'd50});
    offer_sample(16'h0000);
    offer_sample(16'h7FFF);
    wait_idle();

    // Incremental mode; the integral clamp bit must have no effect here.
    write_reg(REG_CONTROL, 32'h6);
    write_reg(REG_GAIN_I, 32'h0040);
    write_reg(REG_GAIN_D, 32'hFF80);
    write_reg(REG_SETPOINT, 32'd100);
    write_reg(REG_INT_UPPER, 32'd2);
    write_reg(REG_INT_FLOOR, 32'd1);
    offer_sample(16'h0000);
    offer_sample(16'h7FFF);
    offer_sample(16'h8000);
    offer_sample(16'd50);
    wait_idle();
    write_reg(REG_CONTROL, 32'h5);
    write_reg(REG_OUT_BOUNDS, OUT_BOUNDS_RST);
    offer_sample(16'h8000);
    offer_sample(16'h7FFF);
    wait_idle();

    // Let the integral build up with the largest errors, upward and then downward.
    write_reg(REG_CONTROL, 32'h0);
    write_reg(REG_GAIN_P, 32'h0);
    write_reg(REG_GAIN_I, 32'h0001);
    write_reg(REG_SETPOINT, 32'h7FFF);
    repeat (20) offer_sample(16'h8000);
    offer_sample(16'h7FFF);
    wait_idle();
    write_reg(REG_SETPOINT, 32'h8000);
    repeat (20) offer_sample(16'h7FFF);
    offer_sample(16'h8000);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      w = $urandom;
      w[CTRL_W-1:0] = 3'($urandom_range(0, 7));
      write_reg(REG_CONTROL, w);
      if ($urandom_range(0, 99) < 70) write_reg(REG_GAIN_P, pad_junk(pick_word16()));
      if ($urandom_range(0, 99) < 70) write_reg(REG_GAIN_I, pad_junk(pick_word16()));
      if ($urandom_range(0, 99) < 70) write_reg(REG_GAIN_D, pad_junk(pick_word16()));
      if ($urandom_range(0, 99) < 60) write_reg(REG_SETPOINT, pad_junk(pick_word16()));
      if ($urandom_range(0, 99) < 60) write_reg(REG_OUT_BOUNDS, pick_out_bounds());
      if ($urandom_range(0, 99) < 60) write_reg(REG_INT_UPPER, pick_int_bound(1'b1));
      if ($urandom_range(0, 99) < 60) write_reg(REG_INT_FLOOR, pick_int_bound(1'b0));
      // No idling in the closing phases.
      if (p >= RAND_PHASES - 2) idle_pct = 0;
      else idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 2 || p == 7) && n == 10) hold_req = 1'b1;
        offer_sample(pick_word16());
      end
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pidc_pkg.sv
rtl/pidc_cfg.sv
rtl/pidc_err.sv
rtl/pidc_mul.sv
rtl/pidc_out.sv
rtl/pid_controller_dual_mode_core.sv
bench/pid_controller_dual_mode_core_tb.sv
